// ===== design/chte_pkg.sv =====
package chte_pkg;

  localparam int DefNumBuckets = 1024;
  localparam int DefNumNodes   = 1024;
  localparam int DefKeyBytes   = 8;
  localparam int DefValueBits  = 32;

  localparam logic [31:0] FnvPrime = 32'h0100_0193;
  localparam logic [31:0] FnvBasis = 32'd2166136261;

  // Operation codes.
  localparam logic [1:0] OpPut = 2'd0;
  localparam logic [1:0] OpGet = 2'd1;
  localparam logic [1:0] OpDel = 2'd2;

  // Status codes.
  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StNotFound = 2'd1;
  localparam logic [1:0] StFull     = 2'd2;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_HASH, S_HEAD_RD, S_HEAD_WT, S_NODE_RD, S_NODE_WT,
    S_CMP, S_ALLOC_RD, S_ALLOC_WT, S_ACT, S_OUT
  } chte_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear_step;
    logic load;
    logic hash_step;
    logic head_rd;
    logic node_rd;
    logic advance;
    logic alloc_rd;
    logic act;
    logic out_load;
  } chte_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_done;
    logic hash_done;
    logic cur_null;
    logic match;
    logic need_alloc;
  } chte_stat_t;

endpackage

// ===== design/chte_datapath.sv =====
module chte_datapath
  import chte_pkg::*;
#(
  parameter int NumBuckets = DefNumBuckets,
  parameter int NumNodes   = DefNumNodes,
  parameter int KeyBytes   = DefKeyBytes,
  parameter int ValueBits  = DefValueBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  chte_cmd_t   cmd_i,
  output chte_stat_t  stat_o,
  input  logic [1:0]  op_i,
  input  logic [63:0] key_i,
  input  logic [3:0]  key_len_i,
  input  logic [31:0] value_in_i,
  output logic [1:0]  status_o,
  output logic        was_new_o,
  output logic [31:0] value_out_o,
  output logic [10:0] entries_o
);

  localparam int BW = $clog2(NumBuckets);
  localparam int NW = $clog2(NumNodes);
  localparam int PW = NW + 1;
  localparam int VB = (ValueBits < 32) ? ValueBits : 32;
  localparam logic [PW-1:0] NoNode = PW'(NumNodes);
  localparam logic [3:0] KeyMax = 4'(KeyBytes);

  // Memories.
  logic [PW-1:0] heads_mem [NumBuckets];
  logic [63:0]   nkey_mem  [NumNodes];
  logic [3:0]    nlen_mem  [NumNodes];
  logic [31:0]   nhash_mem [NumNodes];
  logic [VB-1:0] nval_mem  [NumNodes];
  logic [PW-1:0] nlink_mem [NumNodes];
  logic [NW-1:0] free_mem  [NumNodes];

  logic [1:0]    op_q;
  logic [63:0]   key_q;
  logic [3:0]    len_q, cnt_q;
  logic [VB-1:0] val_q;
  logic [31:0]   hash_q;
  logic [PW-1:0] cur_q, prev_q;
  logic [BW:0]   clr_q;
  logic [PW-1:0] free_cnt_q;
  logic [10:0]   ent_q;
  logic [PW-1:0] head_rd_q, link_rd_q;
  logic [63:0]   key_rd_q;
  logic [3:0]    len_rd_q;
  logic [31:0]   hash_rd_q;
  logic [VB-1:0] val_rd_q;
  logic [NW-1:0] free_node;
  logic [BW-1:0] bkt;
  logic [3:0]    len_c;
  logic [63:0]   key_c;
  logic [31:0]   hash_x;
  logic          match;

  assign bkt = hash_q[BW-1:0];

  // Clamp length and mask unused key bytes on entry.
  always_comb begin
    len_c = (key_len_i > KeyMax) ? KeyMax : key_len_i;
    key_c = key_i;
    for (int i = 0; i < 8; i++) begin
      if (4'(i) >= len_c) key_c[8*i +: 8] = 8'h00;
    end
  end

  assign hash_x = (hash_q ^ {24'h0, key_q[8*cnt_q[2:0] +: 8]}) * FnvPrime;
  assign match  = (hash_rd_q == hash_q) && (len_rd_q == len_q) && (key_rd_q == key_q);

  assign stat_o.clear_done = (clr_q == (BW+1)'(NumBuckets - 1));
  assign stat_o.hash_done  = (cnt_q >= len_q);
  assign stat_o.cur_null   = (cur_q >= NoNode);
  assign stat_o.match      = match;
  assign stat_o.need_alloc = (op_q == OpPut);

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= '0;
      free_cnt_q <= NoNode;
      ent_q      <= '0;
    end else begin
      if (cmd_i.clear_step) clr_q <= clr_q + 1'b1;
      if (cmd_i.act) begin
        if (op_q == OpPut && stat_o.cur_null && free_cnt_q != '0) begin
          free_cnt_q <= free_cnt_q - 1'b1;
          ent_q      <= ent_q + 1'b1;
        end else if (op_q == OpDel && !stat_o.cur_null) begin
          if (free_cnt_q < NoNode) free_cnt_q <= free_cnt_q + 1'b1;
          if (ent_q != '0) ent_q <= ent_q - 1'b1;
        end
      end
    end
  end

  // Request registers, hashing and chain walk.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= op_i;
      key_q  <= key_c;
      len_q  <= len_c;
      val_q  <= value_in_i[VB-1:0];
      hash_q <= FnvBasis;
      cnt_q  <= '0;
      prev_q <= NoNode;
    end
    if (cmd_i.hash_step) begin
      hash_q <= hash_x;
      cnt_q  <= cnt_q + 1'b1;
    end
    if (cmd_i.head_rd) cur_q <= head_rd_q;
    if (cmd_i.advance) begin
      prev_q <= cur_q;
      cur_q  <= link_rd_q;
    end
  end

  // Bucket head memory: clear sweep, read, and updates.
  always_ff @(posedge clk_i) begin
    head_rd_q <= heads_mem[bkt];
    if (cmd_i.clear_step) begin
      heads_mem[clr_q[BW-1:0]] <= NoNode;
    end else if (cmd_i.act) begin
      if (op_q == OpPut && stat_o.cur_null && free_cnt_q != '0) begin
        heads_mem[bkt] <= PW'(free_node);
      end else if (op_q == OpDel && !stat_o.cur_null && prev_q >= NoNode) begin
        heads_mem[bkt] <= link_rd_q;
      end
    end
  end

  // Node memories.
  always_ff @(posedge clk_i) begin
    key_rd_q  <= nkey_mem[cur_q[NW-1:0]];
    len_rd_q  <= nlen_mem[cur_q[NW-1:0]];
    hash_rd_q <= nhash_mem[cur_q[NW-1:0]];
    val_rd_q  <= nval_mem[cur_q[NW-1:0]];
    link_rd_q <= nlink_mem[cur_q[NW-1:0]];
    if (cmd_i.act) begin
      if (op_q == OpPut && !stat_o.cur_null) begin
        nval_mem[cur_q[NW-1:0]] <= val_q;
      end else if (op_q == OpPut && free_cnt_q != '0) begin
        nkey_mem[free_node]  <= key_q;
        nlen_mem[free_node]  <= len_q;
        nhash_mem[free_node] <= hash_q;
        nval_mem[free_node]  <= val_q;
        nlink_mem[free_node] <= head_rd_q;
      end else if (op_q == OpDel && !stat_o.cur_null && prev_q < NoNode) begin
        nlink_mem[prev_q[NW-1:0]] <= link_rd_q;
      end
    end
  end

  // Free stack: slots below the lowest depth ever reached were never pushed,
  // so they read as their reset order.
  logic [PW-1:0] free_low_q;
  logic [NW-1:0] free_raw_q, free_idx;
  logic          free_fresh_q;
  assign free_idx = free_cnt_q[NW-1:0] - 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) free_low_q <= NoNode;
    else if (cmd_i.act && op_q == OpPut && stat_o.cur_null && free_cnt_q != '0 &&
             free_cnt_q <= free_low_q) free_low_q <= free_cnt_q - 1'b1;
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.alloc_rd) begin
      free_raw_q   <= free_mem[free_idx];
      free_fresh_q <= (PW'(free_idx) < free_low_q);
    end
    if (cmd_i.act && op_q == OpDel && !stat_o.cur_null && free_cnt_q < NoNode)
      free_mem[free_cnt_q[NW-1:0]] <= cur_q[NW-1:0];
  end
  always_comb begin
    free_node = free_fresh_q ? NW'(NumNodes - 1) - (free_cnt_q[NW-1:0] - 1'b1) : free_raw_q;
  end

  // Result register; the entry count shows the state after this request.
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      status_o    <= StNotFound;
      was_new_o   <= 1'b0;
      value_out_o <= '0;
      entries_o   <= ent_q;
      if (op_q == OpPut) begin
        if (!stat_o.cur_null) status_o <= StOk;
        else if (free_cnt_q == '0) status_o <= StFull;
        else begin
          status_o  <= StOk;
          was_new_o <= 1'b1;
          entries_o <= ent_q + 1'b1;
        end
      end else if (op_q == OpGet || op_q == OpDel) begin
        if (!stat_o.cur_null) begin
          status_o <= StOk;
          if (op_q == OpGet) value_out_o <= 32'(val_rd_q);
          if (op_q == OpDel && ent_q != '0) entries_o <= ent_q - 1'b1;
        end
      end
    end
  end

endmodule

// ===== design/chte_ctrl.sv =====
module chte_ctrl
  import chte_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  chte_stat_t stat_i,
  output chte_cmd_t  cmd_o,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall
);

  chte_state_e state_q, state_d;
  logic        ov_q, ov_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

  assign out_valid = ov_q;
  assign in_stall  = (state_q != S_IDLE);

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    ov_d    = ov_q && out_stall;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (stat_i.clear_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd_o.load = 1'b1;
          state_d    = S_HASH;
        end
      end
      S_HASH: begin
        if (stat_i.hash_done) state_d = S_HEAD_RD;
        else cmd_o.hash_step = 1'b1;
      end
      S_HEAD_RD: state_d = S_HEAD_WT;
      S_HEAD_WT: begin
        cmd_o.head_rd = 1'b1;
        state_d       = S_NODE_RD;
      end
      S_NODE_RD: begin
        if (stat_i.cur_null) state_d = S_ALLOC_RD;
        else state_d = S_NODE_WT;
      end
      S_NODE_WT: state_d = S_CMP;
      S_CMP: begin
        if (stat_i.match) state_d = S_ACT;
        else begin
          cmd_o.advance = 1'b1;
          state_d       = S_NODE_RD;
        end
      end
      S_ALLOC_RD: begin
        cmd_o.alloc_rd = stat_i.need_alloc;
        state_d        = S_ALLOC_WT;
      end
      S_ALLOC_WT: state_d = S_ACT;
      S_ACT: begin
        if (!ov_q || !out_stall) begin
          cmd_o.act      = 1'b1;
          cmd_o.out_load = 1'b1;
          ov_d           = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

// ===== design/chained_hash_table_engine_core.sv =====
// Chained hash table engine: put, get and delete on keys of up to eight
// bytes with 32-bit values.
// The input channel (in_valid / in_stall) carries one request per beat:
// op_i, key_i, key_len_i and value_in_i. The output channel
// (out_valid / out_stall) returns exactly one result beat per request:
// status_o, was_new_o, value_out_o and entries_o.
// From the accepting edge to out_valid a request passes through the hash
// steps, one per key byte, the head read, then a node read and compare
// for each chain node visited up to and including a match, or on through
// the allocation read states when the key is absent. The next request is
// taken in the cycle after the result is loaded.
// The walk is bounded by the node memory read in each chain step; one
// request is in flight at a time.
// After reset the bucket heads are swept empty, one bucket a cycle, so
// in_stall stays high until the sweep has cleared every bucket.
// The result sits in an output register; the engine takes the next
// request while it waits, and holds before updating state until a
// stalled result has been taken.
module chained_hash_table_engine_core
  import chte_pkg::*;
#(
  parameter int NumBuckets = DefNumBuckets,
  parameter int NumNodes   = DefNumNodes,
  parameter int KeyBytes   = DefKeyBytes,
  parameter int ValueBits  = DefValueBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  op_i,
  input  logic [63:0] key_i,
  input  logic [3:0]  key_len_i,
  input  logic [31:0] value_in_i,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status_o,
  output logic        was_new_o,
  output logic [31:0] value_out_o,
  output logic [10:0] entries_o
);

  chte_cmd_t  cmd;
  chte_stat_t stat;

  chte_ctrl u_ctrl (
    .clk_i, .rst_ni, .stat_i(stat), .cmd_o(cmd),
    .in_valid, .in_stall, .out_valid, .out_stall
  );

  chte_datapath #(
    .NumBuckets(NumBuckets), .NumNodes(NumNodes),
    .KeyBytes(KeyBytes), .ValueBits(ValueBits)
  ) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .stat_o(stat),
    .op_i, .key_i, .key_len_i, .value_in_i,
    .status_o, .was_new_o, .value_out_o, .entries_o
  );

endmodule

// ===== tb/sv/tb_chained_hash_table_engine_core.sv =====
`timescale 1ns / 1ps

module tb_chained_hash_table_engine_core;
  import chte_pkg::*;

  localparam int NumBuckets = DefNumBuckets;
  localparam int NumNodes   = DefNumNodes;
  localparam int KeyBytes   = DefKeyBytes;
  localparam int CycleLimit = 1200000;
  localparam int DrainCycles = 64;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  op_i;
  logic [63:0] key_i;
  logic [3:0]  key_len_i;
  logic [31:0] value_in_i;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  status_o;
  logic        was_new_o;
  logic [31:0] value_out_o;
  logic [10:0] entries_o;

  typedef struct packed {
    logic [1:0]  status;
    logic        was_new;
    logic [31:0] value_out;
    logic [10:0] entries;
  } table_reply_t;

  typedef struct {
    logic [1:0]  op;
    logic [63:0] key;
    logic [3:0]  key_len;
    logic [31:0] value;
    bit          has_fixed;
    table_reply_t fixed;
  } request_row_t;

  chained_hash_table_engine_core uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid(in_valid), .in_stall(in_stall),
    .op_i(op_i), .key_i(key_i), .key_len_i(key_len_i), .value_in_i(value_in_i),
    .out_valid(out_valid), .out_stall(out_stall),
    .status_o(status_o), .was_new_o(was_new_o),
    .value_out_o(value_out_o), .entries_o(entries_o)
  );

  // Clock with a 4 ns period.
  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // Shadow table state.
  int          head_of[NumBuckets];
  logic [63:0] slot_key[NumNodes];
  logic [3:0]  slot_len[NumNodes];
  logic [31:0] slot_hash[NumNodes];
  logic [31:0] slot_value[NumNodes];
  int          slot_next[NumNodes];
  int          free_stack[NumNodes];
  int          free_depth;
  int          live_entries;

  table_reply_t pending_replies[$];
  int  error_count;
  int  cycle_count;
  bit  quiet_phase;
  bit  send_done;
  logic [63:0] key_pool[16];

  function automatic logic [31:0] fnv1a_hash(logic [63:0] k, int len);
    logic [31:0] h;
    h = FnvBasis;
    for (int i = 0; i < len; i++) begin
      h = (h ^ {24'd0, k[8*i +: 8]}) * FnvPrime;
    end
    return h;
  endfunction

  task automatic shadow_reset();
    for (int i = 0; i < NumBuckets; i++) head_of[i] = NumNodes;
    for (int i = 0; i < NumNodes; i++) begin
      slot_next[i] = NumNodes;
      free_stack[i] = NumNodes - 1 - i;
    end
    free_depth = NumNodes;
    live_entries = 0;
  endtask

  // Apply one request to the shadow table and return the reply it gives.
  function automatic table_reply_t table_apply(logic [1:0] op, logic [63:0] key_raw,
                                               logic [3:0] len_raw, logic [31:0] val);
    table_reply_t r;
    int len, b, cur, prev, n;
    logic [63:0] k;
    logic [31:0] h;
    bit found;
    len = (len_raw > KeyBytes) ? KeyBytes : len_raw;
    k = key_raw;
    if (len < 8) k = k & ((64'd1 << (8 * len)) - 64'd1);
    h = fnv1a_hash(k, len);
    b = h & (NumBuckets - 1);
    prev = NumNodes;
    cur = head_of[b];
    found = 1'b0;
    while (cur < NumNodes) begin
      if (slot_hash[cur] == h && slot_len[cur] == len && slot_key[cur] == k) begin
        found = 1'b1;
        break;
      end
      prev = cur;
      cur = slot_next[cur];
    end
    r = '0;
    r.status = StNotFound;
    case (op)
      OpPut: begin
        if (found) begin
          slot_value[cur] = val;
          r.status = StOk;
        end else if (free_depth == 0) begin
          r.status = StFull;
        end else begin
          free_depth--;
          n = free_stack[free_depth];
          slot_key[n] = k;
          slot_len[n] = len;
          slot_hash[n] = h;
          slot_value[n] = val;
          slot_next[n] = head_of[b];
          head_of[b] = n;
          live_entries++;
          r.status = StOk;
          r.was_new = 1'b1;
        end
      end
      OpGet: begin
        if (found) begin
          r.status = StOk;
          r.value_out = slot_value[cur];
        end
      end
      OpDel: begin
        if (found) begin
          if (prev < NumNodes) slot_next[prev] = slot_next[cur];
          else head_of[b] = slot_next[cur];
          free_stack[free_depth] = cur;
          free_depth++;
          live_entries--;
          r.status = StOk;
        end
      end
      default: ;
    endcase
    r.entries = live_entries[10:0];
    return r;
  endfunction

  // Send one request beat, recording its expected reply. Valid stays high
  // after the beat until the next idle cycle or an explicit release.
  task automatic send_request(logic [1:0] op, logic [63:0] key, logic [3:0] len,
                              logic [31:0] val, bit has_fixed, table_reply_t fixed);
    table_reply_t predicted;
    while (!quiet_phase && $urandom_range(99) < 35) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    op_i <= op;
    key_i <= key;
    key_len_i <= len;
    value_in_i <= val;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    predicted = table_apply(op, key, len, val);
    if (has_fixed && predicted !== fixed) begin
      $display("%0t: directed row disagrees: table %h typed %h", $time, predicted, fixed);
      error_count++;
    end
    pending_replies.push_back(has_fixed ? fixed : predicted);
  endtask

  function automatic table_reply_t reply(logic [1:0] st, logic nw, logic [31:0] v,
                                         int ent);
    table_reply_t r;
    r.status = st;
    r.was_new = nw;
    r.value_out = v;
    r.entries = ent[10:0];
    return r;
  endfunction

  // Result checker and stall generator.
  always @(posedge clk_i) begin
    table_reply_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (pending_replies.size() == 0) begin
        $display("%0t: unexpected result beat status %0d", $time, status_o);
        error_count++;
      end else begin
        want = pending_replies.pop_front();
        if (status_o !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, status_o);
          error_count++;
        end
        if (was_new_o !== want.was_new) begin
          $display("%0t: was_new expected %0d actual %0d", $time, want.was_new, was_new_o);
          error_count++;
        end
        if (value_out_o !== want.value_out) begin
          $display("%0t: value_out expected %h actual %h", $time, want.value_out,
                   value_out_o);
          error_count++;
        end
        if (entries_o !== want.entries) begin
          $display("%0t: entries expected %0d actual %0d", $time, want.entries, entries_o);
          error_count++;
        end
      end
    end
    out_stall <= !quiet_phase && ($urandom_range(99) < 35);
  end

  // Watchdog on the cycle count.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  request_row_t rows[$];

  task automatic add_row(logic [1:0] op, logic [63:0] key, logic [3:0] len,
                         logic [31:0] val, bit has_fixed, table_reply_t fixed);
    request_row_t row;
    row.op = op;
    row.key = key;
    row.key_len = len;
    row.value = val;
    row.has_fixed = has_fixed;
    row.fixed = fixed;
    rows.push_back(row);
  endtask

  initial begin
    table_reply_t none;
    logic [1:0] op;
    logic [63:0] key;
    logic [3:0] len;
    int pick;
    none = '0;
    error_count = 0;
    cycle_count = 0;
    quiet_phase = 1'b0;
    send_done = 1'b0;
    rst_ni = 1'b0;
    in_valid = 1'b0;
    op_i = OpPut;
    key_i = '0;
    key_len_i = '0;
    value_in_i = '0;
    out_stall = 1'b0;
    shadow_reset();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed rows: empty table, extremes, long length, ignored bytes, unknown op.
    add_row(OpGet, 64'h0, 4'd0, 32'h0, 1, reply(StNotFound, 0, 0, 0));
    add_row(OpDel, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 32'h0, 1, reply(StNotFound, 0, 0, 0));
    add_row(OpPut, 64'h0, 4'd0, 32'hFFFF_FFFF, 1, reply(StOk, 1, 0, 1));
    add_row(OpGet, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 32'h0, 1,
            reply(StOk, 0, 32'hFFFF_FFFF, 1));
    add_row(OpPut, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 32'h0, 1, reply(StOk, 1, 0, 2));
    add_row(OpGet, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 32'h1234, 1, reply(StOk, 0, 0, 2));
    add_row(OpPut, 64'hFFFF_FFFF_FFFF_FFFF, 4'd9, 32'hA5A5_5A5A, 1, reply(StOk, 0, 0, 2));
    add_row(OpGet, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 32'h0, 0, none);
    add_row(OpPut, 64'hDEAD_BEEF_0000_00AB, 4'd1, 32'h55, 0, none);
    add_row(OpGet, 64'h0000_0000_0000_00AB, 4'd1, 32'h0, 0, none);
    add_row(OpGet, 64'h0000_0000_0000_00AB, 4'd2, 32'h0, 0, none);
    add_row(2'd3, 64'h0000_0000_0000_00AB, 4'd1, 32'h77, 1, reply(StNotFound, 0, 0, 3));
    add_row(OpPut, 64'h0123_4567_89AB_CDEF, 4'd4, 32'h8000_0000, 0, none);
    add_row(OpPut, 64'h0123_4567_89AB_CDEF, 4'd7, 32'h0000_0001, 0, none);
    add_row(OpDel, 64'h0000_0000_0000_00AB, 4'd1, 32'h0, 1, reply(StOk, 0, 0, 4));
    add_row(OpDel, 64'h0000_0000_0000_00AB, 4'd1, 32'h0, 1, reply(StNotFound, 0, 0, 4));
    add_row(OpGet, 64'hFF23_4567_89AB_CDEF, 4'd4, 32'h0, 0, none);
    add_row(OpDel, 64'h0, 4'd0, 32'h0, 1, reply(StOk, 0, 0, 3));
    foreach (rows[i])
      send_request(rows[i].op, rows[i].key, rows[i].key_len, rows[i].value,
                   rows[i].has_fixed, rows[i].fixed);
    in_valid <= 1'b0;

    // Hold off until every reply is in.
    while (pending_replies.size() != 0) @(posedge clk_i);

    // Fill the pool to the top and beyond with numbered keys, so full is reached.
    for (int i = 0; i < NumNodes + 4; i++)
      send_request(OpPut, 64'(i), 4'd8, $urandom, 0, none);

    // Random traffic over the numbered keys, a small key pool and random keys, so
    // that the pool drains from full and hits and chains are common.
    for (int i = 0; i < 16; i++) key_pool[i] = {$urandom, $urandom};
    for (int i = 0; i < 600; i++) begin
      quiet_phase = (i >= 200 && i < 300);
      pick = $urandom_range(99);
      if (pick < 40) begin
        key = key_pool[$urandom_range(15)];
        len = 4'($urandom_range(8));
      end else if (pick < 80) begin
        key = 64'($urandom_range(NumNodes - 1));
        len = 4'd8;
      end else begin
        key = {$urandom, $urandom};
        len = 4'($urandom_range(15));
      end
      pick = $urandom_range(99);
      op = (pick < 35) ? OpPut : (pick < 57) ? OpGet : (pick < 97) ? OpDel : 2'd3;
      send_request(op, key, len, $urandom, 0, none);
    end
    quiet_phase = 1'b0;
    in_valid <= 1'b0;

    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0 && pending_replies.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
